/* src/pcm16_pkg.sv */
package pcm16_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SLOT_W = 3;

  // Register indexes.
  localparam logic [1:0] REG_CONTAINER = 2'd0;
  localparam logic [1:0] REG_FLOAT = 2'd1;
  localparam logic [1:0] REG_VALID = 2'd2;
  localparam logic [1:0] REG_REORDER = 2'd3;

  // One converted word passed from the front part to the back part.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                block_end;
    logic                reorder;
  } conv_word_t;

  // AC3 order FL FC FR BL BR LF to WAVE order FL FR FC LF BL BR.
  function automatic logic [SLOT_W-1:0] pick_slot(input logic [SLOT_W-1:0] k);
    logic [SLOT_W-1:0] p;
    case (k)
      3'd0: p = 3'd0;
      3'd1: p = 3'd2;
      3'd2: p = 3'd1;
      3'd3: p = 3'd5;
      3'd4: p = 3'd3;
      default: p = 3'd4;
    endcase
    return p;
  endfunction

endpackage

/* src/pcm_sample_to_16bit_converter_core.sv */
// An accepted input word passes the conversion register, queue and output register to give its
// result word; in surround mode the first word of a frame follows the frame's sixth input.
// Throughput: one word per cycle in pass-through mode unless out_tready stalls the output;
// a six-word surround frame is collected, then emitted through the single output register.
// Reset (rst_n, synchronous, active low) empties the queue, clears the frame slot and
// loads the registers with 2 bytes, integer mode, 16 valid bits, no reordering.
module pcm_sample_to_16bit_converter_core
  import pcm16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // sample_word[31:0]
  input  logic        in_tlast,  // block_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // sample_out[15:0]
  output logic        out_tlast, // run_last
  output logic        out_tuser, // block_end_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [2:0] cb_r;
  logic       fm_r;
  logic [5:0] vb_r;
  logic       ro_r;
  logic       cv_valid;
  logic       cv_ready;
  conv_word_t cv_data;
  logic       q_valid;
  logic       q_ready;
  conv_word_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r <= 3'd2;
      fm_r <= 1'b0;
      vb_r <= 6'd16;
      ro_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONTAINER: cb_r <= cfg_data[2:0];
        REG_FLOAT: fm_r <= cfg_data[0];
        REG_VALID: vb_r <= cfg_data[5:0];
        REG_REORDER: ro_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pcm16_conv u_conv (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_word(in_tdata), .in_end(in_tlast),
    .container_bytes(cb_r), .float_mode(fm_r), .valid_bits(vb_r),
    .reorder_surround(ro_r),
    .q_valid(cv_valid), .q_ready(cv_ready), .q_data(cv_data)
  );

  pcm16_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(cv_valid), .wr_ready(cv_ready), .wr_data(cv_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  pcm16_emit u_emit (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_sample(out_tdata), .out_last(out_tlast), .out_end(out_tuser)
  );

endmodule

/* src/pcm16_conv.sv */
module pcm16_conv
  import pcm16_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WORD_W-1:0]  in_word,
  input  logic               in_end,
  input  logic [2:0]         container_bytes,
  input  logic               float_mode,
  input  logic [5:0]         valid_bits,
  input  logic               reorder_surround,
  output logic               q_valid,
  input  logic               q_ready,
  output conv_word_t         q_data
);

  logic       valid_r;
  conv_word_t data_r;
  conv_word_t data_nxt;

  logic [7:0]  fexp;
  logic [23:0] mant;
  logic [8:0]  sh;
  logic [39:0] fixd;
  logic [16:0] mag;
  logic [15:0] fres;
  logic [2:0]  cb;
  logic [5:0]  bits;
  logic [5:0]  vb;
  logic [5:0]  drop;
  logic [31:0] raw;
  logic [31:0] msk;
  logic [31:0] shr;
  logic [15:0] ires;

  // Float: value*32768 = mant * 2^(exp-150+15). Keep one fraction bit for rounding.
  always_comb begin
    fexp = in_word[30:23];
    mant = {(fexp != 8'd0), in_word[22:0]};
    fixd = '0;
    mag = '0;
    sh = 9'd0;
    if (fexp == 8'hFF) begin
      if (in_word[22:0] != 23'd0) fres = 16'd0;
      else fres = in_word[31] ? 16'h8000 : 16'h7FFF;
    end else if (fexp >= 8'd127) begin
      // A magnitude of one or more saturates to the 16-bit limits (-1.0 maps exactly to 16'h8000).
      fres = in_word[31] ? 16'h8000 : 16'h7FFF;
    end else begin
      // fixd holds value*32768*2 (one fraction bit) in bits below.
      if (fexp >= 8'd134) begin
        sh = 9'(fexp) - 9'd134;
        fixd = 40'(mant) << sh[3:0];
      end else begin
        sh = 9'd134 - 9'(fexp);
        fixd = (sh > 9'd39) ? 40'd0 : (40'(mant) >> sh[5:0]);
      end
      mag = 17'((fixd + 40'd1) >> 1);
      if (in_word[31]) fres = (mag >= 17'd32768) ? 16'h8000 : 16'(-mag);
      else fres = (mag >= 17'd32767) ? 16'h7FFF : mag[15:0];
    end
  end

  always_comb begin
    cb = container_bytes;
    if (cb == 3'd0) cb = 3'd1;
    if (cb > 3'd4) cb = 3'd4;
    bits = {cb, 3'b000};
    vb = (valid_bits > bits) ? bits : valid_bits;
    drop = bits - vb;
    raw = (cb == 3'd4) ? in_word : (in_word & ((32'd1 << bits) - 32'd1));
    msk = (drop == 6'd32) ? 32'd0 : ~((32'd1 << drop) - 32'd1);
    shr = (raw & msk) >> (bits - 6'd16);
    if (cb == 3'd1) ires = {in_word[7] ^ 1'b1, in_word[6:0], 8'h00};
    else ires = shr[15:0];
  end

  always_comb begin
    data_nxt.sample = float_mode ? fres : ires;
    data_nxt.block_end = in_end;
    data_nxt.reorder = reorder_surround;
  end

  assign in_ready = !valid_r || q_ready;
  assign q_valid = valid_r;
  assign q_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* src/pcm16_fifo.sv */
module pcm16_fifo
  import pcm16_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  conv_word_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output conv_word_t rd_data
);

  conv_word_t mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       wr;
  logic       rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

/* src/pcm16_emit.sv */
module pcm16_emit
  import pcm16_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  conv_word_t          q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample,
  output logic                out_last,
  output logic                out_end
);

  logic [SAMPLE_W-1:0] frame_r [6];
  logic [SLOT_W-1:0]   slot_r;
  logic                burst_r;
  logic [SLOT_W-1:0]   k_r;
  logic                bend_r;
  logic                valid_r;
  logic [SAMPLE_W-1:0] samp_r;
  logic                last_r;
  logic                end_r;
  logic                oreg_free;
  logic                take;

  assign oreg_free = !valid_r || out_ready;
  assign q_ready = !burst_r && (oreg_free || (q_data.reorder && slot_r != 3'd5));
  assign take = q_valid && q_ready;

  assign out_valid = valid_r;
  assign out_sample = samp_r;
  assign out_last = last_r;
  assign out_end = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      burst_r <= 1'b0;
      k_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (burst_r) begin
        if (oreg_free) begin
          valid_r <= 1'b1;
          k_r <= k_r + 3'd1;
          if (k_r == 3'd5) burst_r <= 1'b0;
        end
      end else if (take && !q_data.reorder) begin
        slot_r <= '0;
        valid_r <= 1'b1;
      end else begin
        if (oreg_free) valid_r <= 1'b0;
        if (take) begin
          if (slot_r != 3'd5) begin
            slot_r <= slot_r + 3'd1;
          end else begin
            slot_r <= '0;
            burst_r <= 1'b1;
            k_r <= '0;
          end
        end
      end
    end
    if (take) begin
      frame_r[slot_r] <= q_data.sample;
      bend_r <= q_data.block_end;
      if (!q_data.reorder) begin
        samp_r <= q_data.sample;
        last_r <= 1'b1;
        end_r <= q_data.block_end;
      end
    end
    if (burst_r && oreg_free) begin
      samp_r <= frame_r[pick_slot(k_r)];
      last_r <= (k_r == 3'd5);
      end_r <= bend_r;
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n) slot_r <= 3'd5)
    else $error("frame slot out of range");
  a_no_take_burst: assert property (@(posedge clk) disable iff (!rst_n) burst_r |-> !take)
    else $error("word taken during frame burst");
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (burst_r && oreg_free && k_r == 3'd5) |=> !burst_r && out_last)
    else $error("frame burst did not finish with last");

endmodule
